[sv/binary_to_decimal_ascii_unit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the binary to decimal ASCII unit
// Short forms for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define B2DA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/b2da_pkg.sv]
// ---------------------------------------------------------------------------
// b2da_pkg
// Constants and helpers shared by the binary to decimal ASCII unit.
// ---------------------------------------------------------------------------
package b2da_pkg;

    localparam int        VALUE_W  = 32;
    localparam int        DIGIT_W  = 4;
    localparam int        CHAR_W   = 8;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Ten to the power of the number of positions: first value that no
    // longer fits.
    function automatic logic [63:0] dec_limit(input int digits);
        logic [63:0] lim;
        lim = 64'd1;
        for (int k = 0; k < digits; k++)
        begin
            lim = lim * 64'd10;
        end
        return lim;
    endfunction

endpackage

[sv/binary_to_decimal_ascii_unit.sv]
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// Converts a signed integer to right-aligned decimal ASCII characters.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: drive value and raise start; the item is taken at the
//   rising edge where start is high and busy is low. busy then stays high
//   until the last character of the item is on the result ports.
//   Result channel: DIGITS characters per item, most significant position
//   first, each shown for one cycle with strobe high. last marks the final
//   character; error is high on every character of a negative value or of
//   one with more than DIGITS decimal digits, which all print as spaces.
//   Leading zeros print as spaces; zero prints as a single '0'.
// Timing:
//   The shared shift-and-add-three unit takes one magnitude bit per cycle,
//   then one character leaves per cycle. A new item is taken only once
//   the last character of the previous one is on the result ports.
// Reset clears the sequencer and the strobe; nothing is pending afterwards.
// The receiver cannot stall: every strobe is taken when it is shown.
// ---------------------------------------------------------------------------
`include "binary_to_decimal_ascii_unit_defines.svh"

module binary_to_decimal_ascii_unit
    import b2da_pkg::*;
#(
    parameter int DIGITS = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [VALUE_W-1:0] value,
    output logic                     strobe,
    output logic [CHAR_W-1:0]        character,
    output logic                     last,
    output logic                     error
);

    // Decimal limit and the number of magnitude bits a valid value can use.
    localparam logic [63:0] LIMIT    = dec_limit(DIGITS);
    localparam int          LIM_BITS = $clog2(LIMIT);
    localparam int          BITS     = (LIM_BITS > VALUE_W - 1) ? VALUE_W - 1 : LIM_BITS;
    localparam int          BCD_W    = DIGIT_W * DIGITS;
    localparam int          CNT_W    = (BITS > 1) ? $clog2(BITS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    state_t              state_reg,     state_next;
    logic [CNT_W-1:0]    cnt_reg,       cnt_next;
    logic [BITS-1:0]     mag_reg,       mag_next;
    logic [BCD_W-1:0]    bcd_reg,       bcd_next;
    logic                err_reg,       err_next;
    logic                seen_reg,      seen_next;
    logic                strobe_reg,    strobe_next;
    logic [CHAR_W-1:0]   character_reg, character_next;
    logic                last_reg,      last_next;
    logic                error_reg,     error_next;

    logic                accept;
    logic                out_of_range;
    logic [BCD_W-1:0]    bcd_step;
    logic [DIGIT_W-1:0]  digit;
    logic                final_pos;

    // Shared conversion unit: one magnitude bit per cycle, MSB first.
    b2da_dabble_step #(
        .DIGITS (DIGITS)
    ) u_step (
        .bcd         (bcd_reg),
        .bit_in      (mag_reg[BITS-1]),
        .bcd_shifted (bcd_step)
    );

    assign accept       = start && (state_reg == ST_IDLE);
    // Negative, or too many digits for the positions.
    assign out_of_range = value[VALUE_W-1] || ({32'b0, value} >= LIMIT);
    assign digit        = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign final_pos    = (cnt_reg == '0);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        err_next       = err_reg;
        seen_next      = seen_reg;
        strobe_next    = 1'b0;
        character_next = character_reg;
        last_next      = last_reg;
        error_next     = error_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CONV;
                    cnt_next   = CNT_W'(BITS - 1);
                    mag_next   = value[BITS-1:0];
                    bcd_next   = '0;
                    err_next   = out_of_range;
                    seen_next  = 1'b0;
                end
            end
            ST_CONV:
            begin
                // Advance the conversion by one bit.
                bcd_next = bcd_step;
                mag_next = mag_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (final_pos)
                begin
                    state_next = ST_EMIT;
                    cnt_next   = CNT_W'(DIGITS - 1);
                end
            end
            ST_EMIT:
            begin
                // Drop the top digit each cycle; blank leading zeros, and all digits on error.
                strobe_next = 1'b1;
                last_next   = final_pos;
                error_next  = err_reg;
                if (err_reg || (!seen_reg && digit == '0 && !final_pos))
                begin
                    character_next = CH_SPACE;
                end
                else
                begin
                    character_next = CH_ZERO + CHAR_W'(digit);
                end
                seen_next = seen_reg || (digit != '0);
                bcd_next  = bcd_reg << DIGIT_W;
                cnt_next  = cnt_reg - 1'b1;
                if (final_pos)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            mag_reg       <= '0;
            bcd_reg       <= '0;
            err_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            strobe_reg    <= 1'b0;
            character_reg <= CH_SPACE;
            last_reg      <= 1'b0;
            error_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mag_reg       <= mag_next;
            bcd_reg       <= bcd_next;
            err_reg       <= err_next;
            seen_reg      <= seen_next;
            strobe_reg    <= strobe_next;
            character_reg <= character_next;
            last_reg      <= last_next;
            error_reg     <= error_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign character = character_reg;
    assign last      = last_reg;
    assign error     = error_reg;

    // Checks on the sequencer and the result stream.
    `B2DA_ASSERT_SAME(a_mid_item_busy, strobe && !last, busy,
        "character before the last one shown while not busy")
    `B2DA_ASSERT_NEXT(a_gap_after_last, strobe && last, !strobe,
        "strobe directly after the last character of an item")
    `B2DA_ASSERT_NEXT(a_error_steady, strobe && !last && error, strobe && error,
        "error flag changed within an item")
    `B2DA_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !strobe,
        "accepted item did not hold the unit busy")
    `B2DA_ASSERT_SAME(a_char_set, strobe,
        character == CH_SPACE || (character >= CH_ZERO && character <= CH_NINE),
        "character is neither a space nor a digit")

endmodule

[sv/b2da_dabble_step.sv]
// ---------------------------------------------------------------------------
// b2da_dabble_step
// One shift-and-add-three step of the binary to BCD conversion.
// ---------------------------------------------------------------------------
module b2da_dabble_step
    import b2da_pkg::*;
#(
    parameter int DIGITS = 8
)
(
    input  logic [DIGIT_W*DIGITS-1:0] bcd,
    input  logic                      bit_in,
    output logic [DIGIT_W*DIGITS-1:0] bcd_shifted
);

    logic [DIGIT_W*DIGITS-1:0] adj;

    // Correct every digit of five or more, then shift the next bit in.
    always_comb
    begin
        for (int k = 0; k < DIGITS; k++)
        begin
            adj[DIGIT_W*k +: DIGIT_W] = (bcd[DIGIT_W*k +: DIGIT_W] >= 4'd5)
                ? bcd[DIGIT_W*k +: DIGIT_W] + 4'd3
                : bcd[DIGIT_W*k +: DIGIT_W];
        end
    end

    assign bcd_shifted = {adj[DIGIT_W*DIGITS-2:0], bit_in};

endmodule

[bench/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for binary_to_decimal_ascii_unit: a directed table of
// edge values and error cases, then random values in three idling phases.
// Every accepted value is turned into eight expected characters, and each
// strobe is checked against the oldest one.
// ---------------------------------------------------------------------------
module tb
    import b2da_pkg::*;
();

    localparam int          NUM_POS     = 8;
    localparam logic [63:0] SHOW_LIMIT  = 64'd100000000;   // ten to the NUM_POS
    localparam int          MAX_REPORTS = 10;
    localparam int          PHASE_ITEMS = 160;
    localparam int          DRAIN_WAIT  = 40;

    // One character as it should appear on the result ports.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              lst;
        logic              err;
    } ascii_char_t;

    // Per accepted value: either a hand-written text or a request to predict.
    typedef struct packed {
        bit          typed;
        logic [63:0] text;
        bit          err;
    } value_note_t;

    typedef struct {
        logic signed [VALUE_W-1:0] v;
        bit                        typed;
        logic [63:0]               text;
        bit                        err;
    } directed_row_t;

    localparam int NUM_DIRECTED = 24;

    // Rows with typed = 1 carry the expected text; the rest go through the
    // predictor.
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{32'sd0,          1'b1, "       0", 1'b0},
        '{32'sd99999999,   1'b1, "99999999", 1'b0},
        '{32'sd100000000,  1'b1, "        ", 1'b1},
        '{-32'sd1,         1'b1, "        ", 1'b1},
        '{32'h8000_0000,   1'b1, "        ", 1'b1},
        '{32'h7fff_ffff,   1'b1, "        ", 1'b1},
        '{32'sd9,          1'b1, "       9", 1'b0},
        '{32'sd10,         1'b1, "      10", 1'b0},
        '{32'sd10000000,   1'b1, "10000000", 1'b0},
        '{32'sd12345678,   1'b1, "12345678", 1'b0},
        '{32'sd1,          1'b0, 64'd0, 1'b0},
        '{32'sd7,          1'b0, 64'd0, 1'b0},
        '{32'sd99,         1'b0, 64'd0, 1'b0},
        '{32'sd100,        1'b0, 64'd0, 1'b0},
        '{32'sd1000,       1'b0, 64'd0, 1'b0},
        '{32'sd90909090,   1'b0, 64'd0, 1'b0},
        '{32'sd9999999,    1'b0, 64'd0, 1'b0},
        '{32'sd1000000,    1'b0, 64'd0, 1'b0},
        '{32'sd55555555,   1'b0, 64'd0, 1'b0},
        '{32'sd99999998,   1'b0, 64'd0, 1'b0},
        '{32'sd100000001,  1'b0, 64'd0, 1'b0},
        '{32'sd134217728,  1'b0, 64'd0, 1'b0},
        '{-32'sd100000000, 1'b0, 64'd0, 1'b0},
        '{32'sd24680135,   1'b0, 64'd0, 1'b0}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [VALUE_W-1:0] value;
    logic                      strobe;
    logic [CHAR_W-1:0]         character;
    logic                      last;
    logic                      error;

    ascii_char_t expected_chars [$];
    value_note_t value_notes [$];
    int          mismatches;
    int          idle_pct;

    binary_to_decimal_ascii_unit #(
        .DIGITS(NUM_POS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .value    (value),
        .strobe   (strobe),
        .character(character),
        .last     (last),
        .error    (error)
    );

    always #5 clk = ~clk;

    // Work out the eight characters of one value, most significant position
    // first, and append them to the expected queue.
    function automatic void predict_decimal_chars(input logic signed [VALUE_W-1:0] v);
        logic [63:0]       mag;
        bit                bad;
        logic [CHAR_W-1:0] text [NUM_POS];
        int                pos;
        ascii_char_t       c;
        mag = {32'd0, v};
        bad = v[VALUE_W-1] || (mag >= SHOW_LIMIT);
        for (pos = 0; pos < NUM_POS; pos++)
        begin
            text[pos] = CH_SPACE;
        end
        // Peel digits off the right; zero still yields a single digit.
        if (!bad)
        begin
            pos = NUM_POS - 1;
            do
            begin
                text[pos] = CH_ZERO + CHAR_W'(mag % 64'd10);
                mag       = mag / 64'd10;
                pos--;
            end
            while (mag != 64'd0 && pos >= 0);
        end
        for (pos = 0; pos < NUM_POS; pos++)
        begin
            c.ch  = text[pos];
            c.lst = (pos == NUM_POS - 1);
            c.err = bad;
            expected_chars.push_back(c);
        end
    endfunction

    // Queue a hand-written expectation: eight ASCII bytes packed MSB first.
    function automatic void queue_typed_chars(input logic [63:0] text, input bit err);
        ascii_char_t c;
        for (int pos = 0; pos < NUM_POS; pos++)
        begin
            c.ch  = text[63 - 8*pos -: 8];
            c.lst = (pos == NUM_POS - 1);
            c.err = err;
            expected_chars.push_back(c);
        end
    endfunction

    // Mostly well-formed values of every length, with a share of values just
    // past the limit, negatives and raw 32-bit noise.
    function automatic logic signed [VALUE_W-1:0] random_value();
        int          kind;
        int          ndig;
        int unsigned lim;
        kind = $urandom_range(99);
        ndig = $urandom_range(NUM_POS, 1);
        lim  = 1;
        repeat (ndig) lim = lim * 10;
        if (kind < 72)
            return $urandom_range(lim - 1, 0);
        else if (kind < 80)
            return (kind[0]) ? lim - 1 : lim / 10;
        else if (kind < 87)
            return SHOW_LIMIT[31:0] + $urandom_range(1000, 0);
        else if (kind < 94)
            return {1'b1, 31'($urandom)};
        else
            return $urandom;
    endfunction

    // Offer one value: idle each cycle with the current chance first, then
    // raise start and wait for the edge that takes the item.
    task automatic offer_value(input logic signed [VALUE_W-1:0] v, input bit typed,
                               input logic [63:0] text, input bit err);
        value_note_t note;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        note.typed = typed;
        note.text  = text;
        note.err   = err;
        value_notes.push_back(note);
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Record every accepted item and derive what it must produce.
    always @(posedge clk)
    begin
        value_note_t note;
        if (rst_n && start && !busy)
        begin
            note = value_notes.pop_front();
            if (note.typed)
                queue_typed_chars(note.text, note.err);
            else
                predict_decimal_chars(value);
        end
    end

    // Check each strobed character against the oldest expectation; an extra
    // strobe with nothing waiting is a failure too.
    always @(posedge clk)
    begin
        ascii_char_t want;
        if (rst_n && strobe)
        begin
            if (expected_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected character %h last %b error %b",
                             character, last, error);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (character !== want.ch)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("character: expected %h, got %h", want.ch, character);
                end
                if (last !== want.lst)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("last: expected %b, got %b", want.lst, last);
                end
                if (error !== want.err)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("error: expected %b, got %b", want.err, error);
                end
            end
        end
    end

    // Stop a hung run; the slowest correct run is well under a tenth of this.
    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        value      = '0;
        mismatches = 0;
        idle_pct   = 35;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: directed table, then random values, sender idling often.
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            offer_value(directed_rows[i].v, directed_rows[i].typed,
                        directed_rows[i].text, directed_rows[i].err);
        end
        repeat (PHASE_ITEMS) offer_value(random_value(), 1'b0, 64'd0, 1'b0);

        // Phase two: sender idles most of the time.
        idle_pct = 80;
        repeat (PHASE_ITEMS) offer_value(random_value(), 1'b0, 64'd0, 1'b0);

        // Phase three: back to back, no idling at all.
        idle_pct = 0;
        repeat (PHASE_ITEMS) offer_value(random_value(), 1'b0, 64'd0, 1'b0);
        start <= 1'b0;

        // Drain: let the last item's characters arrive, then watch for strays.
        @(posedge clk);
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && expected_chars.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
